[design/sccnt_pkg.sv]
`timescale 1ns / 1ps
package sccnt_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 21;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    localparam int CENTER_WEIGHT = 10;
    localparam int WEIGHT_LIMIT  = 14;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Window: three 3-bit columns, newest in bits 2:0; per column bit 0 top,
    // bit 1 middle, bit 2 bottom. Center cell is bit 4.
    function automatic logic f_sparse(input logic [8:0] w);
        logic [3:0] pop;
        logic [4:0] weighted;
        pop = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                pop = pop + 4'(w[i]);
            end
        end
        weighted = 5'(pop) + (w[4] ? 5'(CENTER_WEIGHT) : 5'd0);
        return (weighted >= 5'(CENTER_WEIGHT)) && (weighted < 5'(WEIGHT_LIMIT));
    endfunction

endpackage

[design/sparse_cell_counter_core.sv]
`timescale 1ns / 1ps
// Output: o_valid is registered; a frame's last item is accepted into stage 1 and sets o_valid when it leaves stage 1.
// Throughput: one item per cycle; the row store (one read and one write port) carries it,
// with the read-after-write on the same column bypassed. The input stalls only during the reset clearing
// pass or while a frame's last item waits in stage 1 behind a previous total that is still held off.
// Reset: synchronous, active low; counters, total and output valid clear, both sizes go to 1024,
// then a clearing pass walks every column address and zeroes the row store while o_stall stays high.
module sparse_cell_counter_core #(
    parameter int MAX_COLUMNS = sccnt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = sccnt_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sccnt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sccnt_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_occupied,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sccnt_pkg::COUNT_W-1:0] o_sparse_count
);
    import sccnt_pkg::*;

    localparam int CIW = $clog2(MAX_COLUMNS);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);

    // configuration
    logic [CFG_W-1:0] r_grid_columns;
    logic [CFG_W-1:0] r_grid_rows;
    logic [CW-1:0]    cols;
    logic [RW-1:0]    rows;

    // row store: bit 0 two rows up, bit 1 one row up
    logic [1:0]       r_mem [MAX_COLUMNS];
    logic [1:0]       r_rd;
    logic             r_clr_active;
    logic [CIW-1:0]   r_clr_addr;

    // input side counters
    logic [CIW-1:0]   r_col;
    logic [RIW-1:0]   r_row;
    logic             row_end;
    logic             last_row;
    logic             accept;

    // stage 1
    logic             r_s1_valid;
    logic             r_s1_cur;
    logic [CIW-1:0]   r_s1_col;
    logic             r_s1_row_nz;
    logic             r_s1_row_ge2;
    logic             r_s1_row_end;
    logic             r_s1_last_row;
    logic             s1_hold;
    logic             s1_go;

    // window state
    logic [8:0]       r_win;
    logic [1:0]       r_lr1;
    logic [1:0]       r_lr2;
    logic [COUNT_W-1:0] r_total;

    logic             r_o_valid;
    logic [COUNT_W-1:0] r_o_count;

    // stage 1 datapath
    logic             a1m;
    logic             a2m;
    logic [1:0]       wdata;
    logic [8:0]       win_base;
    logic [8:0]       n_win;
    logic [1:0]       lr1_base;
    logic [1:0]       lr2_base;
    logic [1:0]       lr_new;
    logic             keep_c;
    logic             keep_c1;
    logic             keep_c2;
    logic [2:0]       lc0;
    logic [2:0]       lc1;
    logic [2:0]       lc2;
    logic [2:0]       add_n;
    logic [COUNT_W:0] sum;
    logic [COUNT_W-1:0] n_total;
    logic             frame_end;

    // effective sizes: zero reads as one, oversize clamps
    always_comb begin
        if (r_grid_columns == '0) begin
            cols = CW'(1);
        end else if (32'(r_grid_columns) > MAX_COLUMNS) begin
            cols = CW'(MAX_COLUMNS);
        end else begin
            cols = CW'(r_grid_columns);
        end
        if (r_grid_rows == '0) begin
            rows = RW'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_grid_rows);
        end
    end

    assign row_end  = ((CW+1)'(r_col) + (CW+1)'(1)) >= (CW+1)'(cols);
    assign last_row = ((RW+1)'(r_row) + (RW+1)'(1)) >= (RW+1)'(rows);

    assign frame_end = r_s1_row_end && r_s1_last_row;
    assign s1_hold   = frame_end && r_o_valid && i_stall;
    assign s1_go     = r_s1_valid && !s1_hold;
    assign o_stall   = r_clr_active || (r_s1_valid && s1_hold);
    assign accept    = i_valid && !o_stall;

    always_comb begin
        a1m      = r_s1_row_nz  ? r_rd[1] : 1'b0;
        a2m      = r_s1_row_ge2 ? r_rd[0] : 1'b0;
        wdata    = {r_s1_cur, a1m};
        win_base = (r_s1_col == '0) ? '0 : r_win;
        n_win    = {win_base[5:0], r_s1_cur, a1m, a2m};
        lr1_base = (r_s1_col == '0) ? '0 : r_lr1;
        lr2_base = (r_s1_col == '0) ? '0 : r_lr2;
        lr_new   = {r_s1_cur, a1m};

        // last-row view: drop columns at or beyond the current width
        keep_c  = (CW+1)'(r_s1_col) < (CW+1)'(cols);
        keep_c1 = (CW+1)'(r_s1_col) <= (CW+1)'(cols);
        keep_c2 = (CW+1)'(r_s1_col) <= ((CW+1)'(cols) + (CW+1)'(1));
        lc0 = keep_c  ? {1'b0, lr_new}   : 3'b000;
        lc1 = keep_c1 ? {1'b0, lr1_base} : 3'b000;
        lc2 = keep_c2 ? {1'b0, lr2_base} : 3'b000;

        add_n = '0;
        if (r_s1_row_nz && (r_s1_col != '0) && f_sparse(n_win)) begin
            add_n = add_n + 3'd1;
        end
        if (r_s1_row_nz && r_s1_row_end && f_sparse({n_win[5:0], 3'b000})) begin
            add_n = add_n + 3'd1;
        end
        if (r_s1_last_row && (r_s1_col != '0) && f_sparse({lc2, lc1, lc0})) begin
            add_n = add_n + 3'd1;
        end
        if (r_s1_last_row && r_s1_row_end && f_sparse({lc1, lc0, 3'b000})) begin
            add_n = add_n + 3'd1;
        end

        // saturate the total
        sum = (COUNT_W+1)'(r_total) + (COUNT_W+1)'(add_n);
        n_total = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= CFG_SIZE_RESET;
            r_grid_rows    <= CFG_SIZE_RESET;
            r_clr_active   <= 1'b1;
            r_clr_addr     <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_total        <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                    CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + CIW'(1);
                if (32'(r_clr_addr) == MAX_COLUMNS - 1) begin
                    r_clr_active <= 1'b0;
                end
            end

            if (accept) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RIW'(1);
                end else begin
                    r_col <= r_col + CIW'(1);
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_total <= frame_end ? '0 : n_total;
            end

            if (s1_go && frame_end) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur      <= i_occupied;
            r_s1_col      <= r_col;
            r_s1_row_nz   <= r_row != '0;
            r_s1_row_ge2  <= (RIW+1)'(r_row) >= (RIW+1)'(2);
            r_s1_row_end  <= row_end;
            r_s1_last_row <= last_row;
        end
        if (s1_go) begin
            r_win <= n_win;
            r_lr1 <= lr_new;
            r_lr2 <= lr1_base;
        end
        if (s1_go && frame_end) begin
            r_o_count <= n_total;
        end
    end

    // row store: write back from stage 1, read on accept with bypass of that write
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= 2'b00;
        end else if (s1_go) begin
            r_mem[r_s1_col] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (s1_go && (r_s1_col == r_col)) begin
                r_rd <= wdata;
            end else begin
                r_rd <= r_mem[r_col];
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sparse_count = r_o_count;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import sccnt_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_occupied  = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [COUNT_W-1:0]   o_sparse_count;

    sparse_cell_counter_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_occupied     (i_occupied),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sparse_count (o_sparse_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus and expectations
    bit                 cells_to_send[$];
    logic [COUNT_W-1:0] expected_totals[$];
    bit                 idle_on = 1'b0;
    int                 holds_asked = 0;
    int                 mismatch_count = 0;

    // Predictor state and register copies
    logic [CFG_W-1:0]   grid_cols_cfg = CFG_SIZE_RESET;
    logic [CFG_W-1:0]   grid_rows_cfg = CFG_SIZE_RESET;
    bit                 above_two[MAX_COLUMNS_DEF];
    bit                 above_one[MAX_COLUMNS_DEF];
    logic [8:0]         win_bits = '0;
    int                 col_at = 0;
    int                 row_at = 0;
    logic [COUNT_W-1:0] tally = '0;

    function automatic int eff_size(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0) return 1;
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // Occupied center with fewer than four occupied neighbors.
    function automatic void tally_window(input logic [8:0] w);
        int n;
        n = 0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) n += w[i];
        end
        if (w[4] && n < 4 && tally != COUNT_MAX) tally = tally + 1'b1;
    endfunction

    // Bottom-row column built from the stores only: bit 0 above two, bit 1 above one.
    function automatic logic [2:0] border_column(input int x, input int cols);
        if (x < 0 || x >= cols) return 3'b000;
        return {1'b0, above_one[x], above_two[x]};
    endfunction

    function automatic logic [8:0] last_row_window(input int x, input int cols);
        return {border_column(x - 1, cols), border_column(x, cols), border_column(x + 1, cols)};
    endfunction

    task automatic predict_cell(input bit occ, output bit frame_done,
                                output logic [COUNT_W-1:0] frame_total);
        int cols;
        int rows;
        int c;
        int r;
        bit a2;
        bit a1;
        bit row_end;
        bit last_row;
        cols = eff_size(grid_cols_cfg, MAX_COLUMNS_DEF);
        rows = eff_size(grid_rows_cfg, MAX_ROWS_DEF);
        c = col_at;
        r = row_at;
        a2 = above_two[c];
        a1 = above_one[c];
        // mask stale rows at the top of the frame
        if (r == 0) begin
            a1 = 1'b0;
            a2 = 1'b0;
        end else if (r == 1) begin
            a2 = 1'b0;
        end
        if (c == 0) win_bits = '0;
        win_bits = {win_bits[5:0], occ, a1, a2};
        above_two[c] = a1;
        above_one[c] = occ;
        row_end = (c + 1 >= cols);
        last_row = (r + 1 >= rows);
        if (r >= 1) begin
            if (c >= 1) tally_window(win_bits);
            if (row_end) tally_window({win_bits[5:0], 3'b000});
        end
        if (last_row) begin
            if (c >= 1) tally_window(last_row_window(c - 1, cols));
            if (row_end) tally_window(last_row_window(c, cols));
        end
        frame_total = tally;
        frame_done = 1'b0;
        if (row_end) begin
            col_at = 0;
            if (last_row) begin
                frame_done = 1'b1;
                row_at = 0;
                tally = '0;
                win_bits = '0;
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Sender: one item per handshake, random gap after each accepted item while idle_on is set.
    int                 gap_left = 0;
    bit                 frame_done;
    logic [COUNT_W-1:0] frame_total;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_occupied <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_cell(i_occupied, frame_done, frame_total);
                if (frame_done) expected_totals.insert(expected_totals.size(), frame_total);
            end
            if (gap_left != 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cells_to_send.size() != 0) begin
                i_valid <= 1'b1;
                i_occupied <= cells_to_send.pop_front();
                gap_left <= idle_on ? int'($urandom_range(0, 3)) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random waits, plus a long hold-off on request.
    int stall_left = 0;
    int hold_left = 0;
    int holds_served = 0;
    int wait_draw;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_served <= 0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= (hold_left > 1);
        end else if (i_stall) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end else if (idle_on && (o_valid || $urandom_range(0, 3) == 0)) begin
            wait_draw = $urandom_range(0, 3);
            stall_left <= wait_draw;
            i_stall <= (wait_draw != 0);
        end
    end

    // Result check
    logic [COUNT_W-1:0] want_total;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected frame total %0d", o_sparse_count));
            end else begin
                want_total = expected_totals.pop_front();
                if (o_sparse_count !== want_total)
                    report_mismatch($sformatf("sparse_count %0d, want %0d",
                                              o_sparse_count, want_total));
            end
        end
    end

    // Abort when no item moves on either side for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_GRID_COLUMNS) grid_cols_cfg = val;
        else grid_rows_cfg = val;
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        write_reg(CFG_GRID_COLUMNS, cols);
        write_reg(CFG_GRID_ROWS, rows);
    endtask

    // Wait until every item is sent and every frame total has come back.
    task automatic settle();
        do @(posedge i_clk);
        while (cells_to_send.size() != 0 || i_valid || expected_totals.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_frame(input int density, output int n);
        n = eff_size(grid_cols_cfg, MAX_COLUMNS_DEF) * eff_size(grid_rows_cfg, MAX_ROWS_DEF);
        for (int i = 0; i < n; i++)
            cells_to_send.insert(cells_to_send.size(), $urandom_range(0, 99) < density);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return CFG_W'($urandom_range(9, 16));
            end
            default: begin
                return CFG_W'($urandom_range(1, 8));
            end
        endcase
    endfunction

    initial begin
        logic [11:0] pattern;
        int          n;
        int          rand_items;
        int          rand_frames;
        int          frames_here;
        pattern = 12'b1011_0110_1101;
        rand_items = 0;
        rand_frames = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero sizes act as a single-cell frame
        set_grid('0, '0);
        idle_on = 1'b1;
        cells_to_send.insert(cells_to_send.size(), 1'b1);
        cells_to_send.insert(cells_to_send.size(), 1'b0);
        cells_to_send.insert(cells_to_send.size(), 1'b1);
        settle();

        // full 3x3: only the corners stay sparse
        set_grid(CFG_W'(3), CFG_W'(3));
        queue_frame(100, n);
        settle();

        set_grid(CFG_W'(4), CFG_W'(3));
        for (int i = 11; i >= 0; i--) cells_to_send.insert(cells_to_send.size(), pattern[i]);
        settle();

        // single-cell frames with the output held off: fill the block
        set_grid(CFG_W'(1), CFG_W'(1));
        idle_on = 1'b0;
        holds_asked <= holds_asked + 1;
        queue_frame(50, n);
        repeat (39) queue_frame(50, n);
        settle();

        // wide rows, then a tall single column
        idle_on = 1'b1;
        set_grid(CFG_W'(60), CFG_W'(2));
        queue_frame(50, n);
        settle();
        set_grid(CFG_W'(1), CFG_W'(40));
        queue_frame(60, n);
        settle();

        while (rand_items < 230 || rand_frames < 6) begin
            idle_on = ($urandom_range(0, 3) != 0);
            set_grid(pick_size(), pick_size());
            frames_here = $urandom_range(1, 3);
            repeat (frames_here) begin
                queue_frame($urandom_range(0, 100), n);
                rand_items += n;
                rand_frames++;
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_totals.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sparse_cell_counter_core.f]
design/sccnt_pkg.sv
design/sparse_cell_counter_core.sv
tb/tb_top.sv
